FILE: rtl/rbf_pkg.sv
// Shared constants, types and helper functions for the RBF/KNN pattern matcher.
package rbf_pkg;

  localparam int PROTOTYPES   = 64;
  localparam int VECTOR_BYTES = 128;
  localparam int DIST_CEILING = 16384;

  localparam int PID_W  = (PROTOTYPES > 1) ? $clog2(PROTOTYPES) : 1;
  localparam int BI_W   = (VECTOR_BYTES > 1) ? $clog2(VECTOR_BYTES) : 1;
  localparam int LEN_W  = $clog2(VECTOR_BYTES + 1);
  localparam int CNT_W  = $clog2(PROTOTYPES + 1);
  localparam int ADDR_W = PID_W + BI_W;
  localparam int KEY_W  = 16 + PID_W;

  localparam logic [2:0] CMD_LEARN    = 3'd0;
  localparam logic [2:0] CMD_CLASSIFY = 3'd1;
  localparam logic [2:0] CMD_BEGIN    = 3'd2;
  localparam logic [2:0] CMD_END      = 3'd3;
  localparam logic [2:0] CMD_RESTORE  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_LONG    = 2'd3;

  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_NORM      = 3'd1;
  localparam logic [2:0] REG_MIN_FIELD = 3'd2;
  localparam logic [2:0] REG_MAX_FIELD = 3'd3;
  localparam logic [2:0] REG_MAX_PROTO = 3'd4;
  localparam logic [2:0] REG_VEC_LEN   = 3'd5;

  typedef struct packed {
    logic        mode;
    logic        norm;
    logic [15:0] min_field;
    logic [15:0] max_field;
    logic [6:0]  max_protos;
    logic [7:0]  vec_len;
  } cfg_t;

  typedef struct packed {
    logic [15:0] cat;
    logic [15:0] field;
    logic [15:0] floor_val;
  } meta_t;

  typedef struct packed {
    logic       vec_store;
    logic       vec_clear;
    logic       cnt_clear;
    logic       cnt_inc;
    logic       latch;
    logic       comp_start;
    logic       comp_learn;
    logic       commit_start;
    logic       commit_learn;
    logic       scan_start;
    logic       fetch;
    logic       out_load;
    logic [1:0] out_status;
    logic       out_hit;
    logic       out_last;
    logic       out_use_ans;
  } dp_cmd_t;

  typedef struct packed {
    logic overflow;
    logic full;
    logic comp_done;
    logic exists;
    logic n_zero;
    logic commit_done;
    logic scan_done;
    logic out_free;
    logic list_last;
  } dp_sts_t;

  // below the floor gives the floor, otherwise above the ceiling gives the ceiling
  function automatic logic [15:0] clamp_field(input logic [15:0] v, input logic [15:0] lo,
                                              input logic [15:0] hi);
    logic [15:0] r;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

endpackage

FILE: rtl/rbf_cfg.sv
// Configuration register file of the pattern matcher.
module rbf_cfg import rbf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode       <= 1'b0;
      cfg_r.norm       <= 1'b0;
      cfg_r.min_field  <= 16'd2;
      cfg_r.max_field  <= 16'd16384;
      cfg_r.max_protos <= 7'd64;
      cfg_r.vec_len    <= 8'd128;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:      cfg_r.mode       <= cfg_data[0];
        REG_NORM:      cfg_r.norm       <= cfg_data[0];
        REG_MIN_FIELD: cfg_r.min_field  <= cfg_data;
        REG_MAX_FIELD: cfg_r.max_field  <= cfg_data;
        REG_MAX_PROTO: cfg_r.max_protos <= cfg_data[6:0];
        REG_VEC_LEN:   cfg_r.vec_len    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/rbf_ctrl.sv
// Command sequencer: decodes commands and steps the datapath through each run.
module rbf_ctrl import rbf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_cmd,
  input  logic       in_last,
  input  dp_sts_t    sts,
  output dp_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_COMP   = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_FETCH  = 3'd5;
  localparam logic [2:0] S_LIST   = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       loading_r, loading_nxt;
  logic [2:0] op_r, op_nxt;
  logic [1:0] st_r, st_nxt;
  logic       use_ans_r, use_ans_nxt;
  logic       accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    loading_nxt = loading_r;
    op_nxt      = op_r;
    st_nxt      = st_r;
    use_ans_nxt = use_ans_r;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_BEGIN, CMD_END: begin
              cmd.vec_clear = 1'b1;
              cmd.cnt_clear = (in_cmd == CMD_BEGIN);
              loading_nxt   = (in_cmd == CMD_BEGIN);
              st_nxt        = ST_OK;
              use_ans_nxt   = 1'b0;
              state_nxt     = S_OUT;
            end
            CMD_LEARN, CMD_CLASSIFY, CMD_RESTORE: begin
              cmd.vec_store = 1'b1;
              if (in_last) begin
                cmd.latch = 1'b1;
                op_nxt    = in_cmd;
                state_nxt = S_DECIDE;
              end
            end
            default: ;
          endcase
        end
      end
      S_DECIDE: begin
        use_ans_nxt = 1'b0;
        st_nxt      = ST_OK;
        if ((op_r == CMD_LEARN || op_r == CMD_CLASSIFY) && loading_r) begin
          st_nxt        = ST_REFUSED;
          cmd.vec_clear = 1'b1;
          state_nxt     = S_OUT;
        end else if (sts.overflow) begin
          st_nxt        = ST_LONG;
          cmd.vec_clear = 1'b1;
          state_nxt     = S_OUT;
        end else if (op_r == CMD_CLASSIFY) begin
          cmd.comp_start = 1'b1;
          state_nxt      = S_COMP;
        end else if (sts.full) begin
          st_nxt        = ST_FULL;
          cmd.vec_clear = 1'b1;
          state_nxt     = S_OUT;
        end else if (op_r == CMD_LEARN) begin
          cmd.comp_start = 1'b1;
          cmd.comp_learn = 1'b1;
          state_nxt      = S_COMP;
        end else begin
          cmd.commit_start = 1'b1;
          state_nxt        = S_COMMIT;
        end
      end
      S_COMP: begin
        if (sts.comp_done) begin
          if (op_r == CMD_LEARN) begin
            if (sts.exists) begin
              cmd.vec_clear = 1'b1;
              state_nxt     = S_OUT;
            end else begin
              cmd.commit_start = 1'b1;
              cmd.commit_learn = 1'b1;
              state_nxt        = S_COMMIT;
            end
          end else begin
            cmd.vec_clear = 1'b1;
            if (sts.n_zero) begin
              use_ans_nxt = 1'b1;
              state_nxt   = S_OUT;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
        end
      end
      S_COMMIT: begin
        if (sts.commit_done) begin
          cmd.cnt_inc   = 1'b1;
          cmd.vec_clear = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          cmd.fetch = 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: state_nxt = S_LIST;
      S_LIST: begin
        if (sts.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_status  = ST_OK;
          cmd.out_hit     = 1'b1;
          cmd.out_last    = sts.list_last;
          cmd.out_use_ans = 1'b1;
          if (sts.list_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_status  = st_r;
          cmd.out_last    = 1'b1;
          cmd.out_use_ans = use_ans_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      loading_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      loading_r <= loading_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    st_r      <= st_nxt;
    use_ans_r <= use_ans_nxt;
  end

endmodule

FILE: rtl/rbf_dp.sv
// Datapath: vector buffer, prototype memories, distance unit, list scanner, result register.
module rbf_dp import rbf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic [7:0]  in_component,
  input  logic [15:0] in_category,
  input  logic [15:0] in_restore_field,
  input  logic [15:0] in_restore_min_field,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_answer_category,
  output logic        out_hit,
  output logic [5:0]  out_proto_id,
  output logic [15:0] out_proto_distance,
  output logic [15:0] out_proto_category,
  output logic [6:0]  out_proto_count,
  output logic        out_last_result
);

  // memories
  logic [7:0]  proto_mem [2**ADDR_W];
  logic [7:0]  in_mem    [VECTOR_BYTES];
  meta_t       meta_mem  [PROTOTYPES];
  logic [15:0] dist_mem  [PROTOTYPES];

  // vector buffer and store count
  logic [LEN_W-1:0] len_r;
  logic             ovf_r;
  logic [CNT_W-1:0] count_r;
  logic [8:0]       len_lim;
  logic [7:0]       store_lim;
  logic             room;

  // latched command operands
  logic [15:0] lcat_r, lrf_r, lrfl_r;

  // distance pipeline
  logic             busy_r, learn_r;
  logic [CNT_W-1:0] pc_r;
  logic [LEN_W-1:0] ic_r;
  logic             ic_last, pc_last;
  logic             s1_v_r, s1_first_r, s1_last_r;
  logic [PID_W-1:0] s1_p_r;
  logic [7:0]       in_q, pb_q;
  logic [7:0]       diff;
  logic [15:0]      acc_r, acc_base, acc_nxt;
  logic [16:0]      sum;
  logic             s2_v_r;
  logic [PID_W-1:0] s2_p_r;
  logic [15:0]      d_r;
  meta_t            meta_q;
  logic [15:0]      dist_q;
  logic             fire, qual, shrink;
  logic [CNT_W-1:0] n_r, k_r;
  logic [15:0]      best_r, ans_r;
  logic             exists_r;
  logic [PROTOTYPES-1:0] flags_r;

  // commit sweep
  logic            cm_busy_r;
  logic [BI_W:0]   ci_r;
  logic            c1_v_r, c1_keep_r;
  logic [BI_W-1:0] c1_i_r;
  logic [PID_W-1:0] slot;
  meta_t           c_meta;

  // list scanner
  logic             sc_busy_r, q1_v_r, found_r, have_prev_r;
  logic [CNT_W-1:0] sp_r;
  logic [PID_W-1:0] q1_p_r;
  logic [KEY_W-1:0] bk_r, prev_r, key;
  logic             cand;
  logic [PID_W-1:0] sel;

  logic [BI_W-1:0]  in_raddr;
  logic [PID_W-1:0] meta_raddr, dist_raddr;
  logic             comp_act;
  logic             out_valid_r;

  assign len_lim   = (9'(cfg.vec_len) < 9'(VECTOR_BYTES)) ? 9'(cfg.vec_len) : 9'(VECTOR_BYTES);
  assign room      = 9'(len_r) < len_lim;
  assign store_lim = (8'(cfg.max_protos) < 8'(PROTOTYPES)) ? 8'(cfg.max_protos)
                                                             : 8'(PROTOTYPES);
  assign slot      = count_r[PID_W-1:0];
  assign sel       = bk_r[PID_W-1:0];

  assign ic_last  = (LEN_W'(ic_r + 1'b1) == len_r);
  assign pc_last  = (CNT_W'(pc_r + 1'b1) == count_r);
  assign comp_act = busy_r || s1_v_r || s2_v_r;

  assign in_raddr   = cm_busy_r ? ci_r[BI_W-1:0] : ic_r[BI_W-1:0];
  assign meta_raddr = comp_act ? s1_p_r : sel;
  assign dist_raddr = sc_busy_r ? sp_r[PID_W-1:0] : sel;

  assign diff     = (in_q > pb_q) ? (in_q - pb_q) : (pb_q - in_q);
  assign acc_base = s1_first_r ? 16'd0 : acc_r;
  assign sum      = {1'b0, acc_base} + 17'(diff);
  always_comb begin
    if (cfg.norm) acc_nxt = (16'(diff) > acc_base) ? 16'(diff) : acc_base;
    else          acc_nxt = sum[16] ? 16'hFFFF : sum[15:0];
  end

  assign fire   = d_r < meta_q.field;
  assign qual   = cfg.mode || fire;
  assign shrink = s2_v_r && learn_r && fire && (meta_q.cat != lcat_r);

  always_comb begin
    c_meta.cat = lcat_r;
    if (cmd.commit_learn) begin
      c_meta.field     = clamp_field(best_r, cfg.min_field, cfg.max_field);
      c_meta.floor_val = cfg.min_field;
    end else begin
      c_meta.field     = clamp_field(lrf_r, lrfl_r, cfg.max_field);
      c_meta.floor_val = lrfl_r;
    end
  end

  assign key  = {cfg.mode ? dist_q : 16'd0, q1_p_r};
  assign cand = q1_v_r && flags_r[q1_p_r] && (!have_prev_r || key > prev_r) &&
                (!found_r || key < bk_r);

  // memory ports
  always_ff @(posedge clk) begin
    if (cmd.vec_store && room) in_mem[len_r[BI_W-1:0]] <= in_component;
    in_q <= in_mem[in_raddr];
  end

  always_ff @(posedge clk) begin
    if (c1_v_r) proto_mem[{slot, c1_i_r}] <= c1_keep_r ? in_q : 8'd0;
    pb_q <= proto_mem[{pc_r[PID_W-1:0], ic_r[BI_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_start) meta_mem[slot] <= c_meta;
    else if (shrink) meta_mem[s2_p_r] <= '{cat: meta_q.cat,
        field: clamp_field(d_r, meta_q.floor_val, cfg.max_field),
        floor_val: meta_q.floor_val};
    meta_q <= meta_mem[meta_raddr];
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) dist_mem[s2_p_r] <= d_r;
    dist_q <= dist_mem[dist_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_r       <= 1'b0;
      count_r     <= '0;
      busy_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      cm_busy_r   <= 1'b0;
      c1_v_r      <= 1'b0;
      sc_busy_r   <= 1'b0;
      q1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.vec_clear) begin
        len_r <= '0;
        ovf_r <= 1'b0;
      end else if (cmd.vec_store) begin
        if (room) len_r <= LEN_W'(len_r + 1'b1);
        else      ovf_r <= 1'b1;
      end
      if (cmd.cnt_clear)    count_r <= '0;
      else if (cmd.cnt_inc) count_r <= CNT_W'(count_r + 1'b1);

      if (cmd.comp_start) busy_r <= (count_r != '0);
      else if (busy_r && ic_last && pc_last) busy_r <= 1'b0;
      s1_v_r <= busy_r;
      s2_v_r <= s1_v_r && s1_last_r;

      if (cmd.commit_start) cm_busy_r <= 1'b1;
      else if (cm_busy_r && ci_r == (BI_W+1)'(VECTOR_BYTES - 1)) cm_busy_r <= 1'b0;
      c1_v_r <= cm_busy_r;

      if (cmd.scan_start) sc_busy_r <= 1'b1;
      else if (sc_busy_r && CNT_W'(sp_r + 1'b1) == count_r) sc_busy_r <= 1'b0;
      q1_v_r <= sc_busy_r;

      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload and counters
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lcat_r <= in_category;
      lrf_r  <= in_restore_field;
      lrfl_r <= in_restore_min_field;
    end

    if (cmd.comp_start) begin
      pc_r        <= '0;
      ic_r        <= '0;
      learn_r     <= cmd.comp_learn;
      n_r         <= '0;
      k_r         <= '0;
      best_r      <= 16'(DIST_CEILING);
      ans_r       <= 16'd0;
      exists_r    <= 1'b0;
      flags_r     <= '0;
      have_prev_r <= 1'b0;
    end else begin
      if (busy_r) begin
        if (ic_last) begin
          ic_r <= '0;
          pc_r <= CNT_W'(pc_r + 1'b1);
        end else begin
          ic_r <= LEN_W'(ic_r + 1'b1);
        end
      end
      if (s2_v_r) begin
        if (learn_r) begin
          if (fire && meta_q.cat == lcat_r) exists_r <= 1'b1;
          if (d_r < best_r) best_r <= d_r;
        end else if (qual) begin
          flags_r[s2_p_r] <= 1'b1;
          n_r <= CNT_W'(n_r + 1'b1);
          if (d_r < best_r) begin
            best_r <= d_r;
            ans_r  <= meta_q.cat;
          end
        end
      end
      if (cmd.fetch) begin
        prev_r      <= bk_r;
        have_prev_r <= 1'b1;
      end
      if (cmd.out_load && cmd.out_hit) k_r <= CNT_W'(k_r + 1'b1);
    end

    s1_first_r <= (ic_r == '0);
    s1_last_r  <= ic_last;
    s1_p_r     <= pc_r[PID_W-1:0];
    if (s1_v_r) acc_r <= acc_nxt;
    if (s1_v_r && s1_last_r) begin
      d_r    <= acc_nxt;
      s2_p_r <= s1_p_r;
    end

    // commit sweep writes the vector then zero padding
    if (cmd.commit_start) ci_r <= '0;
    else if (cm_busy_r) ci_r <= (BI_W+1)'(ci_r + 1'b1);
    c1_i_r    <= ci_r[BI_W-1:0];
    c1_keep_r <= ci_r < (BI_W+1)'(len_r);

    if (cmd.scan_start) begin
      sp_r    <= '0;
      found_r <= 1'b0;
    end else begin
      if (sc_busy_r) sp_r <= CNT_W'(sp_r + 1'b1);
      if (cand) begin
        bk_r    <= key;
        found_r <= 1'b1;
      end
    end
    q1_p_r <= sp_r[PID_W-1:0];

    if (cmd.out_load) begin
      out_status          <= cmd.out_status;
      out_answer_category <= cmd.out_use_ans ? ans_r : 16'd0;
      out_hit             <= cmd.out_hit;
      out_proto_id        <= cmd.out_hit ? 6'(sel) : 6'd0;
      out_proto_distance  <= cmd.out_hit ? dist_q : 16'd0;
      out_proto_category  <= cmd.out_hit ? meta_q.cat : 16'd0;
      out_proto_count     <= 7'(count_r);
      out_last_result     <= cmd.out_last;
    end
  end

  assign out_valid = out_valid_r;

  assign sts.overflow    = ovf_r;
  assign sts.full        = 8'(count_r) >= store_lim;
  assign sts.comp_done   = !comp_act;
  assign sts.exists      = exists_r;
  assign sts.n_zero      = (n_r == '0);
  assign sts.commit_done = !cm_busy_r && !c1_v_r;
  assign sts.scan_done   = !sc_busy_r && !q1_v_r;
  assign sts.out_free    = !out_valid_r || !out_stall;
  assign sts.list_last   = (CNT_W'(k_r + 1'b1) == n_r);

endmodule

FILE: rtl/rbf_knn_pattern_matcher_core.sv
// Top level of the RBF/KNN pattern matcher.
//
// Input channel (in_*): one vector byte per transfer with a last mark; the
// command on the last byte decides the run. Bytes with last low, and codes 5
// to 7, are taken without a stall. Begin and end restore act at once.
// A vector-ending command holds in_stall high while it runs:
//   compare: one byte of one prototype per cycle from the single prototype
//   memory port;
//   store of a new prototype: a sweep over all VECTOR_BYTES bytes of the row;
//   classify listing: one selection pass over the stored distances per result.
// Result channel (out_*): a registered output; a result is shown for at least
// one cycle and held while out_stall is high, and the sequencer waits for the
// register to free before loading the next result.
// Configuration (cfg_*): always ready; write only while the block is idle.
// Reset clears the sequencer, counts and result register; no memory clearing
// pass is needed since only committed prototypes are ever read.
module rbf_knn_pattern_matcher_core import rbf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_component,
  input  logic        in_last,
  input  logic [15:0] in_category,
  input  logic [15:0] in_restore_field,
  input  logic [15:0] in_restore_min_field,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_answer_category,
  output logic        out_hit,
  output logic [5:0]  out_proto_id,
  output logic [15:0] out_proto_distance,
  output logic [15:0] out_proto_category,
  output logic [6:0]  out_proto_count,
  output logic        out_last_result
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  rbf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rbf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_cmd   (in_cmd),
    .in_last  (in_last),
    .sts      (sts),
    .cmd      (cmd)
  );

  rbf_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_component         (in_component),
    .in_category          (in_category),
    .in_restore_field     (in_restore_field),
    .in_restore_min_field (in_restore_min_field),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_answer_category  (out_answer_category),
    .out_hit              (out_hit),
    .out_proto_id         (out_proto_id),
    .out_proto_distance   (out_proto_distance),
    .out_proto_category   (out_proto_category),
    .out_proto_count      (out_proto_count),
    .out_last_result      (out_last_result)
  );

endmodule

FILE: rtl/rbf_checker.sv
// Port-level checks of the pattern matcher, bound to the top level.
module rbf_checker import rbf_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic        out_hit,
  input logic [5:0]  out_proto_id,
  input logic [6:0]  out_proto_count,
  input logic        out_last_result
);

  // a stalled result stays shown
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_id_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_proto_id) && $stable(out_last_result))
    else $error("stalled result changed");

  // only a listed prototype can be followed by more results
  a_nohit_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_last_result)
    else $error("result without prototype is not final");

  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_status == ST_OK && out_proto_count != 7'd0)
    else $error("listed prototype with bad status or empty store");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind rbf_knn_pattern_matcher_core rbf_checker u_rbf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_hit         (out_hit),
  .out_proto_id    (out_proto_id),
  .out_proto_count (out_proto_count),
  .out_last_result (out_last_result)
);

FILE: dv/testbench.sv
// Self-checking testbench for the RBF/KNN pattern matcher core.
module testbench;
  import rbf_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] answer;
    logic        hit;
    logic [5:0]  id;
    logic [15:0] pdist;
    logic [15:0] cat;
    logic [6:0]  count;
    logic        last_result;
  } match_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_cmd;
  logic [7:0]  in_component;
  logic        in_last;
  logic [15:0] in_category;
  logic [15:0] in_restore_field;
  logic [15:0] in_restore_min_field;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [15:0] out_answer_category;
  logic        out_hit;
  logic [5:0]  out_proto_id;
  logic [15:0] out_proto_distance;
  logic [15:0] out_proto_category;
  logic [6:0]  out_proto_count;
  logic        out_last_result;

  rbf_knn_pattern_matcher_core u_top (.*);

  // shadow copy of the matcher state
  logic [7:0]  sh_rows [PROTOTYPES][VECTOR_BYTES];
  logic [15:0] sh_cat [PROTOTYPES];
  logic [15:0] sh_field [PROTOTYPES];
  logic [15:0] sh_floor [PROTOTYPES];
  logic [15:0] sh_dist [PROTOTYPES];
  logic [7:0]  sh_vec [VECTOR_BYTES];
  int          sh_len;
  int          sh_count;
  bit          sh_loading;
  bit          sh_overflow;
  bit          r_mode;
  bit          r_norm;
  logic [15:0] r_min_field;
  logic [15:0] r_max_field;
  logic [6:0]  r_max_protos;
  logic [7:0]  r_vec_len;

  match_result_t pending_results[$];
  int          n_fail;
  int          n_results;
  int          n_bytes;
  int          n_cfg;
  bit          calm;
  logic [7:0]  base_pat [8];

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [15:0] field_clamp(input int v, input logic [15:0] lo,
                                              input logic [15:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return 16'(v);
  endfunction

  function automatic int len_cap();
    return (r_vec_len < VECTOR_BYTES) ? r_vec_len : VECTOR_BYTES;
  endfunction

  function automatic int store_cap();
    return (r_max_protos < PROTOTYPES) ? r_max_protos : PROTOTYPES;
  endfunction

  function automatic logic [15:0] vec_distance(input int p);
    int d;
    int diff;
    d = 0;
    for (int i = 0; i < sh_len; i++) begin
      diff = (sh_vec[i] > sh_rows[p][i]) ? sh_vec[i] - sh_rows[p][i]
                                         : sh_rows[p][i] - sh_vec[i];
      if (r_norm) begin
        if (diff > d) d = diff;
      end else begin
        d += diff;
      end
    end
    return (d > 65535) ? 16'hFFFF : 16'(d);
  endfunction

  task automatic queue_result(input match_result_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic push_status(input logic [1:0] st);
    match_result_t r;
    r = '0;
    r.status = st;
    r.count = 7'(sh_count);
    r.last_result = 1'b1;
    queue_result(r);
  endtask

  task automatic commit_proto(input logic [15:0] cat, input logic [15:0] fld,
                              input logic [15:0] flo);
    int p;
    p = sh_count % PROTOTYPES;
    for (int i = 0; i < VECTOR_BYTES; i++) sh_rows[p][i] = (i < sh_len) ? sh_vec[i] : 8'h00;
    sh_cat[p] = cat;
    sh_field[p] = fld;
    sh_floor[p] = flo;
    sh_dist[p] = '0;
    sh_count++;
  endtask

  task automatic learn_vector(input logic [15:0] cat);
    int best;
    bit found;
    logic [15:0] d;
    best = DIST_CEILING;
    found = 0;
    for (int p = 0; p < sh_count; p++) begin
      d = vec_distance(p);
      sh_dist[p] = d;
      if (d < sh_field[p]) begin
        if (sh_cat[p] == cat) found = 1;
        else sh_field[p] = field_clamp(d, sh_floor[p], r_max_field);
      end
      if (d < best) best = d;
    end
    if (!found) commit_proto(cat, field_clamp(best, r_min_field, r_max_field), r_min_field);
  endtask

  task automatic classify_vector();
    int order [PROTOTYPES];
    int n;
    int best;
    int j;
    int v;
    logic [15:0] ans;
    logic [15:0] d;
    match_result_t r;
    n = 0;
    best = DIST_CEILING;
    ans = '0;
    for (int p = 0; p < sh_count; p++) begin
      d = vec_distance(p);
      if (r_mode || d < sh_field[p]) begin
        if (d < best) begin
          best = d;
          ans = sh_cat[p];
        end
        sh_dist[p] = d;
        order[n++] = p;
      end
    end
    // stable sort by distance, ties stay in index order
    if (r_mode) begin
      for (int i = 1; i < n; i++) begin
        v = order[i];
        j = i;
        while (j > 0 && sh_dist[order[j-1]] > sh_dist[v]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = v;
      end
    end
    if (n == 0) begin
      r = '0;
      r.answer = ans;
      r.count = 7'(sh_count);
      r.last_result = 1'b1;
      queue_result(r);
    end
    for (int i = 0; i < n; i++) begin
      r = '0;
      r.answer = ans;
      r.hit = 1'b1;
      r.id = 6'(order[i]);
      r.pdist = sh_dist[order[i]];
      r.cat = sh_cat[order[i]];
      r.count = 7'(sh_count);
      r.last_result = (i + 1 == n);
      queue_result(r);
    end
  endtask

  task automatic predict_transfer(input logic [2:0] cmd, input logic [7:0] comp,
                                  input logic last, input logic [15:0] cat,
                                  input logic [15:0] rfield, input logic [15:0] rfloor);
    if (cmd > CMD_RESTORE) return;
    if (cmd == CMD_BEGIN || cmd == CMD_END) begin
      if (cmd == CMD_BEGIN) sh_count = 0;
      sh_loading = (cmd == CMD_BEGIN);
      sh_len = 0;
      sh_overflow = 0;
      push_status(ST_OK);
      return;
    end
    if (sh_len < len_cap()) sh_vec[sh_len++] = comp;
    else sh_overflow = 1;
    if (!last) return;
    if ((cmd == CMD_LEARN || cmd == CMD_CLASSIFY) && sh_loading) push_status(ST_REFUSED);
    else if (sh_overflow) push_status(ST_LONG);
    else if (cmd == CMD_CLASSIFY) classify_vector();
    else if (sh_count >= store_cap()) push_status(ST_FULL);
    else begin
      if (cmd == CMD_LEARN) learn_vector(cat);
      else commit_proto(cat, field_clamp(rfield, rfloor, r_max_field), rfloor);
      push_status(ST_OK);
    end
    sh_len = 0;
    sh_overflow = 0;
  endtask

  task automatic send_byte(input logic [2:0] cmd, input logic [7:0] comp, input logic last,
                           input logic [15:0] cat, input logic [15:0] rfield,
                           input logic [15:0] rfloor);
    if (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_component <= comp;
    in_last <= last;
    in_category <= cat;
    in_restore_field <= rfield;
    in_restore_min_field <= rfloor;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_transfer(cmd, comp, last, cat, rfield, rfloor);
    n_bytes++;
  endtask

  function automatic logic [7:0] pattern_byte(input int i);
    if ($urandom_range(1)) return base_pat[i % 8] + 8'($urandom_range(0, 6)) - 8'd3;
    return 8'($urandom);
  endfunction

  // stream a vector; earlier bytes may carry other vector commands
  task automatic send_vector(input logic [2:0] cmd, input int len, input logic [15:0] cat,
                             input logic [15:0] rfield, input logic [15:0] rfloor);
    logic [2:0] lead_cmd;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(2))
        0: lead_cmd = CMD_LEARN;
        1: lead_cmd = CMD_CLASSIFY;
        default: lead_cmd = CMD_RESTORE;
      endcase
      if (i == len - 1) lead_cmd = cmd;
      send_byte(lead_cmd, pattern_byte(i), i == len - 1, cat, rfield, rfloor);
    end
  endtask

  task automatic send_marker(input logic [2:0] cmd);
    send_byte(cmd, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // a store writes its whole row before its status result is shown
    repeat (VECTOR_BYTES + 20) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MODE:      r_mode = data[0];
      REG_NORM:      r_norm = data[0];
      REG_MIN_FIELD: r_min_field = data;
      REG_MAX_FIELD: r_max_field = data;
      REG_MAX_PROTO: r_max_protos = data[6:0];
      REG_VEC_LEN:   r_vec_len = data[7:0];
      default: ;
    endcase
    n_cfg++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic report(input string name, input logic [15:0] e, input logic [15:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $realtime, name, e, a);
      n_fail++;
    end
  endtask

  // result monitor and receiver stall
  always @(posedge clk) begin
    match_result_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 12);
      if (out_valid && !out_stall) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d id %0d",
                   $realtime, out_status, out_proto_id);
          n_fail++;
        end else begin
          e = pending_results.pop_front();
          report("status", 16'(e.status), 16'(out_status));
          report("answer_category", e.answer, out_answer_category);
          report("hit", 16'(e.hit), 16'(out_hit));
          report("proto_id", 16'(e.id), 16'(out_proto_id));
          report("proto_distance", e.pdist, out_proto_distance);
          report("proto_category", e.cat, out_proto_category);
          report("proto_count", 16'(e.count), 16'(out_proto_count));
          report("last_result", 16'(e.last_result), 16'(out_last_result));
        end
      end
    end
  end

  task automatic test_directed();
    send_byte(CMD_LEARN, 8'h00, 1'b1, 16'hFFFF, 16'h0000, 16'h0000);
    send_byte(CMD_CLASSIFY, 8'hFF, 1'b0, 16'h0001, 16'hFFFF, 16'hFFFF);
    send_byte(CMD_LEARN, 8'hFF, 1'b1, 16'h0001, 16'h0000, 16'h0000);
    send_byte(CMD_CLASSIFY, 8'hFF, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    // unused codes are ignored, also in the middle of a vector
    send_byte(CMD_CLASSIFY, 8'h80, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    send_byte(CMD_RESTORE + 3'd1, 8'h55, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_byte(CMD_RESTORE + 3'd3, 8'hAA, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    send_byte(CMD_CLASSIFY, 8'h7F, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    // restore outside restore mode, then a restore session cut into a partial vector
    send_byte(CMD_RESTORE, 8'h40, 1'b1, 16'h0002, 16'h0100, 16'h0200);
    send_byte(CMD_LEARN, 8'h11, 1'b0, 16'h0003, 16'h0000, 16'h0000);
    send_byte(CMD_BEGIN, 8'h22, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    send_byte(CMD_LEARN, 8'h33, 1'b1, 16'h0003, 16'h0000, 16'h0000);
    send_byte(CMD_CLASSIFY, 8'h33, 1'b1, 16'h0003, 16'h0000, 16'h0000);
    send_byte(CMD_RESTORE, 8'h10, 1'b0, 16'h0004, 16'hFFFF, 16'h0000);
    send_byte(CMD_RESTORE, 8'h20, 1'b1, 16'h0004, 16'hFFFF, 16'h0000);
    send_byte(CMD_RESTORE, 8'h30, 1'b1, 16'h0005, 16'h0000, 16'hFFFF);
    send_byte(CMD_END, 8'h00, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_byte(CMD_CLASSIFY, 8'h10, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    // empty store lists nothing
    send_byte(CMD_BEGIN, 8'h00, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_byte(CMD_END, 8'h00, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    send_byte(CMD_CLASSIFY, 8'h00, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    drain();
  endtask

  task automatic test_extremes();
    cfg_write(REG_MIN_FIELD, 16'hFFFF);
    cfg_write(REG_MAX_FIELD, 16'h0000);
    cfg_write(REG_VEC_LEN, 16'd1);
    send_vector(CMD_LEARN, 1, 16'h0007, 16'h0, 16'h0);
    send_vector(CMD_LEARN, 3, 16'h0007, 16'h0, 16'h0);
    send_vector(CMD_CLASSIFY, 1, 16'h0, 16'h0, 16'h0);
    drain();
    cfg_write(REG_MAX_PROTO, 16'd0);
    cfg_write(3'd6, 16'hFFFF);
    cfg_write(3'd7, 16'h0000);
    send_vector(CMD_LEARN, 1, 16'h0008, 16'h0, 16'h0);
    send_vector(CMD_RESTORE, 1, 16'h0008, 16'h0, 16'h0);
    drain();
    cfg_write(REG_MIN_FIELD, 16'h0000);
    cfg_write(REG_MAX_FIELD, 16'hFFFF);
    cfg_write(REG_MAX_PROTO, 16'd64);
    cfg_write(REG_VEC_LEN, 16'd128);
    cfg_write(REG_MODE, 16'd1);
    cfg_write(REG_NORM, 16'd1);
    send_vector(CMD_CLASSIFY, VECTOR_BYTES, 16'h0, 16'h0, 16'h0);
    drain();
    // fill the store, then list every prototype
    send_marker(CMD_BEGIN);
    for (int i = 0; i < PROTOTYPES + 1; i++)
      send_vector(CMD_RESTORE, 1, 16'($urandom), 16'($urandom), 16'($urandom));
    send_marker(CMD_END);
    send_vector(CMD_LEARN, 2, 16'h000A, 16'h0, 16'h0);
    send_vector(CMD_CLASSIFY, 2, 16'h0, 16'h0, 16'h0);
    drain();
  endtask

  task automatic test_random(input bit knn, input bit l_inf, input int target);
    int stop;
    int pick;
    stop = n_bytes + target;
    cfg_write(REG_MODE, 16'(knn));
    cfg_write(REG_NORM, 16'(l_inf));
    cfg_write(REG_MIN_FIELD, 16'($urandom_range(0, 40)));
    cfg_write(REG_MAX_FIELD, 16'($urandom_range(60, 2000)));
    cfg_write(REG_MAX_PROTO, 16'($urandom_range(4, 24)));
    cfg_write(REG_VEC_LEN, 16'($urandom_range(3, 8)));
    while (n_bytes < stop) begin
      calm = (n_bytes > stop - target / 3);
      if ($urandom_range(9) == 0)
        for (int i = 0; i < 8; i++) base_pat[i] = 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 42)
        send_vector(CMD_LEARN, $urandom_range(1, 6), 16'($urandom_range(0, 3)), 16'h0, 16'h0);
      else if (pick < 78)
        send_vector(CMD_CLASSIFY, $urandom_range(1, 6), 16'($urandom), 16'($urandom),
                    16'($urandom));
      else if (pick < 84)
        send_vector(CMD_RESTORE, $urandom_range(1, 6), 16'($urandom), 16'($urandom),
                    16'($urandom));
      else if (pick < 90) begin
        send_marker(CMD_BEGIN);
        repeat ($urandom_range(1, 4))
          send_vector(CMD_RESTORE, $urandom_range(1, 5), 16'($urandom_range(0, 3)),
                      16'($urandom), 16'($urandom_range(0, 300)));
        send_marker(CMD_END);
      end else if (pick < 94)
        send_marker(CMD_RESTORE + 3'($urandom_range(1, 3)));
      else if (pick < 97)
        send_vector(CMD_LEARN, $urandom_range(9, 11), 16'($urandom), 16'h0, 16'h0);
      else begin
        send_vector(CMD_LEARN, 1, 16'h0, 16'h0, 16'h0);
        send_marker($urandom_range(1) ? CMD_BEGIN : CMD_END);
      end
    end
    calm = 0;
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_cmd = CMD_LEARN;
    in_component = '0;
    in_last = 1'b0;
    in_category = '0;
    in_restore_field = '0;
    in_restore_min_field = '0;
    calm = 0;
    n_fail = 0;
    n_results = 0;
    n_bytes = 0;
    n_cfg = 0;
    sh_len = 0;
    sh_count = 0;
    sh_loading = 0;
    sh_overflow = 0;
    r_mode = 0;
    r_norm = 0;
    r_min_field = 16'd2;
    r_max_field = 16'd16384;
    r_max_protos = 7'd64;
    r_vec_len = 8'd128;
    for (int i = 0; i < 8; i++) base_pat[i] = 8'($urandom);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1'b0, 1'b0, 16);
    test_random(1'b1, 1'b0, 16);
    test_random(1'b0, 1'b1, 16);
    test_random(1'b1, 1'b1, 16);
    test_extremes();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d input transfers, %0d results, %0d register writes,",
             n_bytes, n_results, n_cfg);
    $display("both modes and norms, restore sessions, full and overlong vectors.");
    if (n_fail == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
